// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define KF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition on one edge implies a condition on the next edge.
`define KF_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/kf1d_pkg.sv =====
// Shared types, constants and saturation helpers of the 1-D Kalman filter.
package kf1d_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int QuotWidth = DataWidth + FracBits;
  localparam int DIV_STEPS = QuotWidth;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int ExtWidth  = QuotWidth + 1;

  localparam logic signed [ExtWidth-1:0] VMax = ExtWidth'(64'sd2147483647);
  localparam logic signed [ExtWidth-1:0] VMin = -VMax - ExtWidth'(1);

  typedef logic signed [DataWidth-1:0] word_t;
  typedef logic signed [ExtWidth-1:0] ext_t;

  // A clamped word and whether clamping took place.
  typedef struct packed {
    logic signed [DataWidth-1:0] val;
    logic                        ovf;
  } sat_t;

  function automatic sat_t sat_s(input ext_t v);
    sat_t r;
    if (v > VMax) begin
      r.val = VMax[DataWidth-1:0];
      r.ovf = 1'b1;
    end else if (v < VMin) begin
      r.val = VMin[DataWidth-1:0];
      r.ovf = 1'b1;
    end else begin
      r.val = v[DataWidth-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  function automatic ext_t ext_s(input word_t v);
    return {{(ExtWidth-DataWidth){v[DataWidth-1]}}, v};
  endfunction

  function automatic ext_t ext_u(input logic [DataWidth-2:0] v);
    return {{(ExtWidth-DataWidth+1){1'b0}}, v};
  endfunction

  function automatic logic [DataWidth-1:0] mag_s(input word_t v);
    logic [DataWidth-1:0] r;
    r = v[DataWidth-1] ? DataWidth'(-v) : v;
    return r;
  endfunction

  // Applies a sign to a magnitude and clamps to the word range.
  function automatic sat_t sign_clamp(input logic neg, input logic [QuotWidth-1:0] m);
    ext_t v;
    v = {1'b0, m};
    if (neg) begin
      v = -v;
    end
    return sat_s(v);
  endfunction

endpackage

// ===== hw/rtl/kf1d_div.sv =====
// Restoring divider that forms (a << 16) / d one quotient bit per cycle.
module kf1d_div import kf1d_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DataWidth-1:0]      dividend_i,
  input  logic [DataWidth-2:0]      divisor_i,
  output logic                      done_o,
  output logic [QuotWidth-1:0]      quot_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DataWidth-1:0] rem_q, rem_d;
  logic [QuotWidth-1:0] num_q;
  logic [DataWidth-2:0] den_q;
  logic [DataWidth-1:0] trial;
  logic                 ge;

  always_comb begin
    trial = {rem_q[DataWidth-2:0], num_q[QuotWidth-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? trial - {1'b0, den_q} : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      num_q <= {dividend_i, {FracBits{1'b0}}};
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[QuotWidth-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ===== hw/rtl/kf1d_mul.sv =====
// Two-stage fractional multiplier with round-to-nearest and saturation.
module kf1d_mul import kf1d_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t a_i,
  input  word_t b_i,
  output logic  done_o,
  output sat_t  res_o
);

  localparam logic [2*DataWidth-1:0] Rnd = (2*DataWidth)'(1) << (FracBits - 1);

  logic                   v1_q, done_q, neg_q;
  logic [2*DataWidth-1:0] prod_q, rsum;
  sat_t                   res_q;

  assign rsum = prod_q + Rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      done_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= mag_s(a_i) * mag_s(b_i);
      neg_q  <= a_i[DataWidth-1] ^ b_i[DataWidth-1];
    end
    if (v1_q) begin
      res_q <= sign_clamp(neg_q, rsum[FracBits +: QuotWidth]);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== hw/rtl/kalman_filter_1d_const_velocity_unit.sv =====
// Top level of the two-state constant-velocity Kalman filter.
//
//  channel | direction | handshake                    | word
//  --------+-----------+------------------------------+-----------------------------
//  in      | input     | in_valid_i / in_stall_o      | meas_pos_i
//  out     | output    | out_valid_o / out_stall_i    | est_pos_o .. var_vel_o,
//          |           |                              | overflow_o
//  cfg     | input     | cfg_we_i, cfg_idx_i          | cfg_data_i
//
// Each of the two gain divisions runs on the bit-serial divider: a start state (ST_DIVK),
// 48 quotient bits and a wait state (ST_DIVW) that takes the quotient. Each of the five
// products runs on the shared two-stage multiplier through ST_MULS and ST_MULW, and
// prediction (ST_PRED) and the output load (ST_DONE) follow. The next word is taken
// only after the previous one has left ST_DONE.
// Reset (rst_ni, asynchronous) loads the register defaults and the initial state.
// The input is stalled for the whole step; a finished result waits in the output
// register, and the block takes the next input word while it waits, stalling only at
// the end of that next step.
module kalman_filter_1d_const_velocity_unit import kf1d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [31:0] meas_pos_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] est_pos_o,
  output logic signed [31:0] est_vel_o,
  output logic signed [31:0] var_pos_o,
  output logic signed [31:0] cov_pos_vel_o,
  output logic signed [31:0] var_vel_o,
  output logic        overflow_o,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  // Configuration register indexes.
  typedef enum logic [3:0] {
    REG_R_NOISE  = 4'd0,
    REG_Q_POS    = 4'd1,
    REG_Q_CROSS  = 4'd2,
    REG_Q_VEL    = 4'd3,
    REG_U_POS    = 4'd4,
    REG_U_VEL    = 4'd5,
    REG_INIT_POS = 4'd6,
    REG_INIT_VEL = 4'd7
  } reg_idx_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIVK = 7'b0000010,
    ST_DIVW = 7'b0000100,
    ST_MULS = 7'b0001000,
    ST_MULW = 7'b0010000,
    ST_PRED = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  // The five correction products, in issue order.
  typedef enum logic [2:0] {
    MOP_KP_Y  = 3'd0,
    MOP_KV_Y  = 3'd1,
    MOP_KP_PP = 3'd2,
    MOP_KP_PV = 3'd3,
    MOP_KV_PV = 3'd4
  } mop_e;

  localparam logic [30:0] RNoiseRst  = 31'd65536;
  localparam logic [30:0] InitVarRst = 31'd65536000;

  state_e state_q;
  mop_e   mop_q;
  logic   div_sel_q;

  // Configuration registers.
  logic [30:0] r_noise_q, q_pos_q, q_vel_q, init_pos_q, init_vel_q;
  word_t       q_cross_q, u_pos_q, u_vel_q;

  // Filter state.
  word_t pos_q, vel_q, ppp_q, ppv_q, pvv_q;

  // Per-step working registers.
  word_t       y_q, kp_q, kv_q, npos_q, nvel_q, npp_q, npv_q, nvv_q;
  logic [30:0] s_q;
  logic        ovf_q;

  // Output register.
  logic  out_valid_q, ovf_out_q;
  word_t o_pos_q, o_vel_q, o_pp_q, o_pv_q, o_vv_q;

  logic        accept, load_out;
  ext_t        s_raw;
  sat_t        y_s, s_s, k_s, wb_s;
  sat_t        p_pos, p_vel, p_pp, p_pv, p_vv;
  word_t       div_src, mul_a, mul_b, wb_base;
  logic        div_start, div_done, mul_start, mul_done;
  logic [QuotWidth-1:0] div_quot;
  sat_t        mul_res;
  logic        restart;
  logic [30:0] new_init_pos, new_init_vel;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign load_out   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign div_start  = (state_q == ST_DIVK);
  assign mul_start  = (state_q == ST_MULS);
  assign div_src    = div_sel_q ? ppv_q : ppp_q;

  // Innovation and its variance, formed as the word is taken, and the signed gain from the quotient.
  always_comb begin
    y_s   = sat_s(ext_s(meas_pos_i) - ext_s(pos_q));
    s_raw = ext_s(ppp_q) + ext_u(r_noise_q);
    if (s_raw < ext_t'(1)) begin
      s_raw = ext_t'(1);
    end
    s_s = sat_s(s_raw);
    k_s = sign_clamp(div_src[DataWidth-1], div_quot);
  end

  // Operand selection for the shared multiplier and write-back of the corrected terms.
  always_comb begin
    mul_a   = kp_q;
    mul_b   = y_q;
    wb_base = pos_q;
    case (mop_q)
      MOP_KP_Y: begin
        mul_a   = kp_q;
        mul_b   = y_q;
        wb_base = pos_q;
      end
      MOP_KV_Y: begin
        mul_a   = kv_q;
        mul_b   = y_q;
        wb_base = vel_q;
      end
      MOP_KP_PP: begin
        mul_a   = kp_q;
        mul_b   = ppp_q;
        wb_base = ppp_q;
      end
      MOP_KP_PV: begin
        mul_a   = kp_q;
        mul_b   = ppv_q;
        wb_base = ppv_q;
      end
      MOP_KV_PV: begin
        mul_a   = kv_q;
        mul_b   = ppv_q;
        wb_base = pvv_q;
      end
      default: begin
        mul_a   = kp_q;
        mul_b   = y_q;
        wb_base = pos_q;
      end
    endcase
    if (mop_q inside {MOP_KP_Y, MOP_KV_Y}) begin
      wb_s = sat_s(ext_s(wb_base) + ext_s(mul_res.val));
    end else begin
      wb_s = sat_s(ext_s(wb_base) - ext_s(mul_res.val));
    end
  end

  // Prediction through the constant-velocity model plus noise and offsets.
  always_comb begin
    p_pos = sat_s(ext_s(npos_q) + ext_s(nvel_q) + ext_s(u_pos_q));
    p_vel = sat_s(ext_s(nvel_q) + ext_s(u_vel_q));
    p_pp  = sat_s(ext_s(npp_q) + ext_s(npv_q) + ext_s(npv_q) + ext_s(nvv_q)
                  + ext_u(q_pos_q));
    p_pv  = sat_s(ext_s(npv_q) + ext_s(nvv_q) + ext_s(q_cross_q));
    p_vv  = sat_s(ext_s(nvv_q) + ext_u(q_vel_q));
  end

  // A write to either initial variance restarts the filter.
  always_comb begin
    restart      = cfg_we_i && (cfg_idx_i inside {REG_INIT_POS, REG_INIT_VEL});
    new_init_pos = (cfg_idx_i == REG_INIT_POS) ? cfg_data_i[30:0] : init_pos_q;
    new_init_vel = (cfg_idx_i == REG_INIT_VEL) ? cfg_data_i[30:0] : init_vel_q;
  end

  kf1d_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(mag_s(div_src)),
    .divisor_i (s_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  kf1d_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mop_q       <= MOP_KP_Y;
      div_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            div_sel_q <= 1'b0;
            state_q   <= ST_DIVK;
          end
        end
        ST_DIVK: begin
          state_q <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_done) begin
            if (div_sel_q) begin
              mop_q   <= MOP_KP_Y;
              state_q <= ST_MULS;
            end else begin
              div_sel_q <= 1'b1;
              state_q   <= ST_DIVK;
            end
          end
        end
        ST_MULS: begin
          state_q <= ST_MULW;
        end
        ST_MULW: begin
          if (mul_done) begin
            if (mop_q == MOP_KV_PV) begin
              state_q <= ST_PRED;
            end else begin
              mop_q   <= mop_e'(mop_q + 3'd1);
              state_q <= ST_MULS;
            end
          end
        end
        ST_PRED: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Configuration registers and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_noise_q  <= RNoiseRst;
      q_pos_q    <= '0;
      q_cross_q  <= '0;
      q_vel_q    <= '0;
      u_pos_q    <= '0;
      u_vel_q    <= '0;
      init_pos_q <= InitVarRst;
      init_vel_q <= InitVarRst;
      pos_q      <= '0;
      vel_q      <= '0;
      ppp_q      <= {1'b0, InitVarRst};
      ppv_q      <= '0;
      pvv_q      <= {1'b0, InitVarRst};
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_R_NOISE:  r_noise_q  <= cfg_data_i[30:0];
          REG_Q_POS:    q_pos_q    <= cfg_data_i[30:0];
          REG_Q_CROSS:  q_cross_q  <= cfg_data_i;
          REG_Q_VEL:    q_vel_q    <= cfg_data_i[30:0];
          REG_U_POS:    u_pos_q    <= cfg_data_i;
          REG_U_VEL:    u_vel_q    <= cfg_data_i;
          REG_INIT_POS: init_pos_q <= cfg_data_i[30:0];
          REG_INIT_VEL: init_vel_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (restart) begin
        pos_q <= '0;
        vel_q <= '0;
        ppv_q <= '0;
        ppp_q <= {1'b0, new_init_pos};
        pvv_q <= {1'b0, new_init_vel};
      end else if (state_q == ST_PRED) begin
        pos_q <= p_pos.val;
        vel_q <= p_vel.val;
        ppp_q <= p_pp.val;
        ppv_q <= p_pv.val;
        pvv_q <= p_vv.val;
      end
    end
  end

  // Working registers of one step; the overflow flag collects every saturation.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      y_q   <= y_s.val;
      s_q   <= s_s.val[30:0];
      ovf_q <= y_s.ovf | s_s.ovf;
    end
    if (state_q == ST_DIVW && div_done) begin
      if (div_sel_q) begin
        kv_q <= k_s.val;
      end else begin
        kp_q <= k_s.val;
      end
      ovf_q <= ovf_q | k_s.ovf;
    end
    if (state_q == ST_MULW && mul_done) begin
      case (mop_q)
        MOP_KP_Y:  npos_q <= wb_s.val;
        MOP_KV_Y:  nvel_q <= wb_s.val;
        MOP_KP_PP: npp_q  <= wb_s.val;
        MOP_KP_PV: npv_q  <= wb_s.val;
        MOP_KV_PV: nvv_q  <= wb_s.val;
        default: ;
      endcase
      ovf_q <= ovf_q | mul_res.ovf | wb_s.ovf;
    end
    if (state_q == ST_PRED) begin
      ovf_q <= ovf_q | p_pos.ovf | p_vel.ovf | p_pp.ovf | p_pv.ovf | p_vv.ovf;
    end
    if (load_out) begin
      o_pos_q   <= pos_q;
      o_vel_q   <= vel_q;
      o_pp_q    <= ppp_q;
      o_pv_q    <= ppv_q;
      o_vv_q    <= pvv_q;
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign est_pos_o     = o_pos_q;
  assign est_vel_o     = o_vel_q;
  assign var_pos_o     = o_pp_q;
  assign cov_pos_vel_o = o_pv_q;
  assign var_vel_o     = o_vv_q;
  assign overflow_o    = ovf_out_q;

endmodule

// ===== hw/rtl/kf1d_checker.sv =====
// Port-level checker for the Kalman filter unit and its bind statement.
`include "assert_macros.svh"

module kf1d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic signed [31:0] meas_pos_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic signed [31:0] est_pos_o,
  input logic signed [31:0] est_vel_o,
  input logic signed [31:0] var_pos_o,
  input logic signed [31:0] cov_pos_vel_o,
  input logic signed [31:0] var_vel_o,
  input logic        overflow_o,
  input logic        cfg_we_i
);

  // An accepted word keeps the unit busy on the following cycle.
  `KF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A stalled input word stays valid and unchanged.
  `KF_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i && $stable(meas_pos_i))

  // A stalled result stays valid and unchanged.
  `KF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(est_pos_o) && $stable(est_vel_o) && $stable(var_pos_o) && $stable(cov_pos_vel_o) && $stable(var_vel_o) && $stable(overflow_o))

  // A new result only appears at the end of a step, while the input is stalled.
  `KF_ASSERT(a_result_from_step, clk_i, rst_ni, !$rose(out_valid_o) || $past(in_stall_o))

  // Registers are written only while no word is in flight.
  `KF_ASSERT(a_cfg_idle, clk_i, rst_ni, !cfg_we_i || (!in_stall_o && !out_valid_o))

endmodule

bind kalman_filter_1d_const_velocity_unit kf1d_checker u_kf1d_checker (.*);
